// ===== hw/rtl/lmc_pkg.sv =====
// shared types and constants for the 3x3 local minimum counter
package lmc_pkg;

  localparam int CFG_BITS     = 9;
  localparam int COUNT_BITS   = 16;
  localparam int RES_DEPTH    = 4;
  localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  // where a sample sits in the frame, worked out when it is accepted
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_col;
    logic last_row;
  } pos_flags_t;

endpackage

// ===== hw/rtl/lmc_queue.sv =====
// small register fifo with count and head read
module lmc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       valid,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (32'(p) == DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  assign valid = (count_r != '0);
  assign full  = (32'(count_r) == DEPTH);
  assign count = count_r;
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop) rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) count_r <= count_r + NW'(1);
      else if (pop && !push) count_r <= count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== hw/rtl/lmc_front.sv =====
// frame position tracking and classification of accepted samples
module lmc_front #(
  parameter int MAX_SIDE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lmc_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                          beat,
  output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] col,
  output lmc_pkg::pos_flags_t           flags
);
  import lmc_pkg::*;

  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int RESET_SIDE = (MAX_SIDE < 8) ? MAX_SIDE : 8;

  logic [CW-1:0] side_m1_r, side_m1_nxt;
  logic [CW-1:0] col_r, row_r;
  logic [31:0]   wval;

  // zero acts as one, anything past the buffer depth saturates
  always_comb begin
    wval = 32'(cfg_wdata);
    if (wval == 32'd0) side_m1_nxt = '0;
    else if (wval > 32'(MAX_SIDE)) side_m1_nxt = CW'(MAX_SIDE - 1);
    else side_m1_nxt = CW'(wval - 32'd1);
  end

  always_comb begin
    flags.r_ge1    = (row_r != '0);
    flags.r_ge2    = (row_r > CW'(1));
    flags.c_ge1    = (col_r != '0);
    flags.c_ge2    = (col_r > CW'(1));
    flags.last_col = (col_r == side_m1_r);
    flags.last_row = (row_r == side_m1_r);
  end

  assign col = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_m1_r <= CW'(RESET_SIDE - 1);
      col_r     <= '0;
      row_r     <= '0;
    end else if (cfg_we) begin
      side_m1_r <= side_m1_nxt;
      col_r     <= '0;
      row_r     <= '0;
    end else if (beat) begin
      if (flags.last_col) begin
        col_r <= '0;
        row_r <= flags.last_row ? '0 : row_r + CW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/lmc_back.sv =====
// line buffers, 3x3 window, minimum decisions and frame count
module lmc_back #(
  parameter int MAX_SIDE    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              q_valid,
  input  logic signed [SAMPLE_BITS-1:0]     q_sample,
  input  logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] q_col,
  input  lmc_pkg::pos_flags_t               q_flags,
  output logic                              q_pop,
  input  logic [lmc_pkg::RES_CNT_BITS-1:0]  res_count,
  output logic                              res_push,
  output logic [lmc_pkg::COUNT_BITS-1:0]    res_data
);
  import lmc_pkg::*;

  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SB = SAMPLE_BITS;

  typedef logic signed [SB-1:0] win_t [3][3];

  // line buffer entry: row two above in the high half, row above in the low half
  logic [2*SB-1:0] line_mem [MAX_SIDE];
  logic [2*SB-1:0] rd_r;

  logic                 a_valid_r, b_valid_r, c_valid_r;
  logic                 a_last, b_last_r, c_last_r;
  logic signed [SB-1:0] a_sample_r;
  logic [CW-1:0]        a_col_r;
  pos_flags_t           a_flags_r, b_flags_r;
  win_t                 win_r, win_nxt;
  logic [3:0]           hits_r, hits_nxt;
  logic [COUNT_BITS-1:0] count_r, count_sat;
  logic [COUNT_BITS:0]   count_sum;
  logic [2:0]            hit_total;
  logic [RES_CNT_BITS:0] reserved;
  logic                  q_last;

  function automatic logic is_min(input win_t w, input int cr, input int cc,
                                  input logic up, input logic down,
                                  input logic left, input logic right);
    logic hit;
    logic use_n;
    int   nr;
    int   nc;
    hit = 1'b1;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        nr = cr + dr - 1;
        nc = cc + dc - 1;
        use_n = !(dr == 1 && dc == 1) && (dr != 0 || up) && (dr != 2 || down)
                && (dc != 0 || left) && (dc != 2 || right)
                && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2;
        if (use_n && (w[nr][nc] <= w[cr][cc])) hit = 1'b0;
      end
    end
    return hit;
  endfunction

  // a frame-closing beat pops only when its result has a slot reserved
  assign q_last   = q_flags.last_col && q_flags.last_row;
  assign a_last   = a_flags_r.last_col && a_flags_r.last_row;
  assign reserved = {1'b0, res_count} + (RES_CNT_BITS+1)'(a_valid_r && a_last)
                    + (RES_CNT_BITS+1)'(b_valid_r && b_last_r)
                    + (RES_CNT_BITS+1)'(c_valid_r && c_last_r);
  assign q_pop    = q_valid && (!q_last || 32'(reserved) < RES_DEPTH);

  always_ff @(posedge clk) begin
    if (q_pop) rd_r <= line_mem[q_col];
    if (a_valid_r) line_mem[a_col_r] <= {rd_r[SB-1:0], a_sample_r};
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = rd_r[2*SB-1:SB];
    win_nxt[1][2] = rd_r[SB-1:0];
    win_nxt[2][2] = a_sample_r;
  end

  // four centers that may be settled by the newest column
  always_comb begin
    hits_nxt[0] = b_flags_r.r_ge1 && b_flags_r.c_ge1
                  && is_min(win_r, 1, 1, b_flags_r.r_ge2, 1'b1, b_flags_r.c_ge2, 1'b1);
    hits_nxt[1] = b_flags_r.r_ge1 && b_flags_r.last_col
                  && is_min(win_r, 1, 2, b_flags_r.r_ge2, 1'b1, b_flags_r.c_ge1, 1'b0);
    hits_nxt[2] = b_flags_r.last_row && b_flags_r.c_ge1
                  && is_min(win_r, 2, 1, b_flags_r.r_ge1, 1'b0, b_flags_r.c_ge2, 1'b1);
    hits_nxt[3] = b_flags_r.last_row && b_flags_r.last_col
                  && is_min(win_r, 2, 2, b_flags_r.r_ge1, 1'b0, b_flags_r.c_ge1, 1'b0);
  end

  always_comb begin
    hit_total = 3'(hits_r[0]) + 3'(hits_r[1]) + 3'(hits_r[2]) + 3'(hits_r[3]);
    count_sum = {1'b0, count_r} + (COUNT_BITS+1)'(hit_total);
    count_sat = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
  end

  assign res_push = c_valid_r && c_last_r;
  assign res_data = count_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      count_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win_r[i][j] <= '0;
      end
    end else begin
      a_valid_r <= q_pop;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      if (a_valid_r) win_r <= win_nxt;
      if (cfg_we) count_r <= '0;
      else if (c_valid_r) count_r <= c_last_r ? '0 : count_sat;
    end
  end

  always_ff @(posedge clk) begin
    a_sample_r <= q_sample;
    a_col_r    <= q_col;
    a_flags_r  <= q_flags;
    b_flags_r  <= a_flags_r;
    b_last_r   <= a_last;
    hits_r     <= hits_nxt;
    c_last_r   <= b_last_r;
  end

endmodule

// ===== hw/rtl/local_minimum_counter_3x3.sv =====
// top level of the strict 3x3 local minimum counter
//
// channel | dir | signals                        | contents
// in_     | in  | in_tvalid in_tready in_tdata   | sample, one frame element per beat
// out_    | out | out_tvalid out_tready out_tdata| minima_count, one beat per frame
// cfg_    | in  | cfg_we cfg_wdata               | side_length
//
// one sample per cycle while the result queue has room; out_tvalid rises once the frame's last
// beat has passed the queue pop, line buffer read, window and compare stages
// the line buffers have no clear after reset; reset brings side_length to 8
// a stalled output holds up to four counts, then frame-closing beats wait in the queue
// writing side_length drops the frame in progress
module local_minimum_counter_3x3 #(
  parameter int MAX_SIDE    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,  // sample
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [15:0]                            out_tdata,  // minima_count
  input  logic                                   cfg_we,
  input  logic [lmc_pkg::CFG_BITS-1:0]           cfg_wdata
);
  import lmc_pkg::*;

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int FW    = $bits(pos_flags_t);
  localparam int QW    = SAMPLE_BITS + CW + FW;
  localparam int QDEPTH = 4;

  logic                         beat;
  logic [CW-1:0]                f_col;
  pos_flags_t                   f_flags;
  logic [QW-1:0]                q_wdata, q_rdata;
  logic                         q_valid, q_full, q_pop;
  logic [$clog2(QDEPTH+1)-1:0]  q_count;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic [CW-1:0]                q_col;
  pos_flags_t                   q_flags;
  logic                         res_push, res_full;
  logic [COUNT_BITS-1:0]        res_data;
  logic [RES_CNT_BITS-1:0]      res_count;

  assign in_tready = !q_full;
  assign beat      = in_tvalid && in_tready;

  lmc_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .beat     (beat),
    .col      (f_col),
    .flags    (f_flags)
  );

  assign q_wdata = {in_tdata[SAMPLE_BITS-1:0], f_col, f_flags};

  lmc_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (beat),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .valid(q_valid),
    .full (q_full),
    .count(q_count)
  );

  assign q_sample = q_rdata[QW-1 -: SAMPLE_BITS];
  assign q_col    = q_rdata[FW +: CW];
  assign q_flags  = q_rdata[FW-1:0];

  lmc_back #(.MAX_SIDE(MAX_SIDE), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .q_valid  (q_valid),
    .q_sample (q_sample),
    .q_col    (q_col),
    .q_flags  (q_flags),
    .q_pop    (q_pop),
    .res_count(res_count),
    .res_push (res_push),
    .res_data (res_data)
  );

  lmc_queue #(.WIDTH(COUNT_BITS), .DEPTH(RES_DEPTH)) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_data),
    .pop  (out_tvalid && out_tready),
    .rdata(out_tdata),
    .valid(out_tvalid),
    .full (res_full),
    .count(res_count)
  );

  // the slot reservation must keep the result queue from overflowing
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full && !(out_tvalid && out_tready)))
    else $error("result pushed into a full result queue");

  // a count shows up only after the back end produced one
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(res_push))
    else $error("result appeared without a push");

  // after an accepted beat the command queue is non-empty and never holds more entries than its depth
  a_cmd_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    beat |=> (32'(q_count) <= QDEPTH && q_valid))
    else $error("command queue lost an accepted beat");

endmodule

// ===== test/local_minimum_counter_3x3_tb.sv =====
// testbench for the 3x3 local minimum counter: random frames checked against a frame-level predictor
module local_minimum_counter_3x3_tb;
  import lmc_pkg::*;

  localparam int SIDE_CAP      = 256;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int MODE_BUDGET   = 270;

  // collects the samples of the frame in progress and works out its minima count
  class minima_board;
    int unsigned side;
    shortint frame_q[$];
    int unsigned counts_q[$];
    int errors;
    int frames_seen;
    int samples_seen;

    function new();
      side = 8;
    endfunction

    function void set_side(int unsigned value);
      if (value == 0) side = 1;
      else if (value > SIDE_CAP) side = SIDE_CAP;
      else side = value;
      frame_q.delete();
    endfunction

    function int unsigned frame_minima();
      int unsigned total;
      int rr;
      int cc;
      bit hit;
      shortint centre;
      total = 0;
      for (int r = 0; r < side; r++) begin
        for (int c = 0; c < side; c++) begin
          centre = frame_q[r * side + c];
          hit = 1'b1;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && rr < side && cc >= 0 && cc < side)
                if (centre >= frame_q[rr * side + cc]) hit = 1'b0;
            end
          end
          if (hit && total < 16'hFFFF) total++;
        end
      end
      return total;
    endfunction

    function void note_sample(shortint value);
      frame_q.push_back(value);
      samples_seen++;
      if (frame_q.size() == side * side) begin
        counts_q.push_back(frame_minima());
        frame_q.delete();
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_count(logic [15:0] got);
      int unsigned want;
      if (counts_q.size() == 0) begin
        report_mismatch($sformatf("count %0d arrived with no frame pending", got));
      end else begin
        want = counts_q.pop_front();
        frames_seen++;
        if (got !== want[15:0])
          report_mismatch($sformatf("frame %0d: minima_count %0d, want %0d",
                                    frames_seen, got, want));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;   // sample
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;  // minima_count
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  logic hold_req;
  int   hold_left;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   random_sent;

  minima_board board = new();

  local_minimum_counter_3x3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side: random stalls, plus one long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_count(out_tdata);
  end

  task automatic send_sample(input shortint value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    board.note_sample(value);
  endtask

  // drop valid, drain every pending count, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (board.counts_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(input int unsigned value);
    cfg_wdata <= value[CFG_BITS-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_side(value);
  endtask

  // styles: full range, tiny range for ties, near the extremes, two plateaus
  function automatic shortint pick_sample(int unsigned style);
    case (style)
      0: return shortint'($urandom);
      1: return shortint'(int'($urandom_range(3)) - 2);
      2: return shortint'($urandom_range(1) ? 16'h8000 + $urandom_range(3)
                                           : 16'h7FFF - $urandom_range(3));
      default: return $urandom_range(1) ? -16'sd32768 : 16'sd32767;
    endcase
  endfunction

  task automatic send_run(input int unsigned style, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_sample(pick_sample(style));
    random_sent += count;
  endtask

  task automatic run_segment();
    int unsigned pick;
    int unsigned side_cfg;
    int unsigned frames;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 8) side_cfg = 0;
    else if (pick < 20) side_cfg = 1;
    else if (pick < 70) side_cfg = $urandom_range(2, 6);
    else if (pick < 90) side_cfg = $urandom_range(7, 11);
    else side_cfg = $urandom_range(12, 16);
    write_side(side_cfg);
    n = board.side;
    frames = (n * n > 100) ? 1 : $urandom_range(1, 4);
    for (int unsigned f = 0; f < frames; f++) send_run($urandom_range(3), n * n);
    // sometimes leave a frame unfinished so the next write drops it
    if (n > 1 && $urandom_range(99) < 30)
      send_run($urandom_range(3), $urandom_range(1, n * n - 1));
    wait_idle();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    hold_req      = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 52;
    random_sent   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one frame at the size reset leaves behind
    send_run(0, 64);
    wait_idle();

    // single-element frames count their only sample
    write_side(1);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    wait_idle();
    write_side(0);
    send_sample(16'sd0);
    wait_idle();

    // flat frame has no strict minimum; a lone corner low does count
    write_side(2);
    repeat (4) send_sample(16'sd7);
    send_sample(-16'sd32768);
    repeat (3) send_sample(16'sd32767);
    wait_idle();

    write_side(3);
    for (int i = 0; i < 9; i++) send_sample(i == 4 ? -16'sd1 : 16'sd5);
    wait_idle();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 52 : 0;
      recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 8 : 0;
      while (random_sent < MODE_BUDGET * (mode + 1)) run_segment();
    end

    // long output stall with a count per beat: the block must back up its input
    write_side(1);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_run(0, 40);
    wait_idle();

    // oversize setting saturates; drop it partway through the second row
    write_side(511);
    send_run(1, 300);
    wait_idle();
    write_side(8);

    repeat (20) @(posedge clk);
    if (board.counts_q.size() != 0)
      board.report_mismatch($sformatf("%0d counts never arrived", board.counts_q.size()));
    $display("%0d samples sent, %0d frame counts checked, sides 0 to 511 written",
             board.samples_seen, board.frames_seen);
    $display("stalls on both sides, one long output hold, dropped partial frames");
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
